// ----- rtl/laqs_pkg.sv -----
// Shared types and constants for the load-adaptive quality stepper.
`timescale 1ns / 1ps

package laqs_pkg;

    localparam int BUDGET_W = 20;
    localparam int TIME_W   = 26;
    localparam int AMOUNT_W = 24;
    localparam int ACC_W    = 32;
    localparam int LEVEL_W  = 3;
    localparam int CLASS_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Highest degradation stage.
    localparam logic [LEVEL_W-1:0] LAST_LEVEL = 3'd5;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_NEUTRAL = 2'd0,
        CLASS_OVER    = 2'd1,
        CLASS_UNDER   = 2'd2
    } t_class;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_BUDGET = 2'd0,
        REG_DOWNGRADE    = 2'd1,
        REG_UPGRADE      = 2'd2,
        REG_COOLDOWN     = 2'd3
    } t_reg_index;

    localparam logic [BUDGET_W-1:0] BUDGET_RST    = 20'd16667;
    localparam logic [TIME_W-1:0]   DOWNGRADE_RST = 26'd2000000;
    localparam logic [TIME_W-1:0]   UPGRADE_RST   = 26'd8000000;
    localparam logic [TIME_W-1:0]   COOLDOWN_RST  = 26'd4000000;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

endpackage

// ----- rtl/laqs_if.sv -----
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface laqs_in_if import laqs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [AMOUNT_W-1:0] amount_us;

    modport source (output valid, output kind, output amount_us, input ready);
    modport sink   (input valid, input kind, input amount_us, output ready);
endinterface

interface laqs_out_if import laqs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;
    logic               level_changed;
    logic [CLASS_W-1:0] load_class;

    modport source (output valid, output level, output level_changed, output load_class,
                    input ready);
    modport sink   (input valid, input level, input level_changed, input load_class,
                    output ready);
endinterface

// ----- rtl/load_adaptive_quality_stepper.sv -----
// Top level: load-adaptive quality stepper with input and result registers.
`timescale 1ns / 1ps

// Every input transaction yields exactly one result transaction. An item is
// captured in an input register, updated against the held state by
// combinational compare/add logic, and written to a result register; one
// item is taken per cycle while the result side keeps up.
// Work samples (kind 0) reclassify load against frame_budget_us; ticks
// (kind 1) count down the cooldown, build the over/under time (saturating at
// 2^32-1) and may step the stage between 0 and 5. Write configuration only
// while no transaction is in flight.

module load_adaptive_quality_stepper import laqs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TIME_W-1:0]    i_cfg_data,
    laqs_in_if.sink              i_in,
    laqs_out_if.source           o_out
);

    // configuration
    logic [BUDGET_W-1:0] r_cfg_budget;
    logic [TIME_W-1:0]   r_cfg_downgrade;
    logic [TIME_W-1:0]   r_cfg_upgrade;
    logic [TIME_W-1:0]   r_cfg_cooldown;

    // input register
    logic                r_in_valid;
    logic                r_in_kind;
    logic [AMOUNT_W-1:0] r_in_amount;

    // block state
    t_class              r_class;
    logic [ACC_W-1:0]    r_over;
    logic [ACC_W-1:0]    r_under;
    logic [TIME_W-1:0]   r_cooldown;
    logic [LEVEL_W-1:0]  r_level;

    // result register
    logic                r_out_valid;
    logic [LEVEL_W-1:0]  r_out_level;
    logic                r_out_changed;
    t_class              r_out_class;

    logic                s_adv;
    t_class              w_sample_class;
    t_class              n_class;
    logic [ACC_W-1:0]    n_over;
    logic [ACC_W-1:0]    n_under;
    logic [TIME_W-1:0]   n_cooldown;
    logic [LEVEL_W-1:0]  n_level;
    logic                n_changed;
    logic [TIME_W-1:0]   w_cd_dec;
    logic [ACC_W:0]      w_over_sum;
    logic [ACC_W:0]      w_under_sum;
    logic [ACC_W-1:0]    w_over_acc;
    logic [ACC_W-1:0]    w_under_acc;
    logic                w_step_up;
    logic                w_step_dn;

    assign s_adv       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || s_adv;

    assign o_out.valid         = r_out_valid;
    assign o_out.level         = r_out_level;
    assign o_out.level_changed = r_out_changed;
    assign o_out.load_class    = r_out_class;

    laqs_classify u_classify (
        .i_amount_us (r_in_amount),
        .i_budget_us (r_cfg_budget),
        .o_class     (w_sample_class)
    );

    always_comb begin
        w_cd_dec    = (r_cooldown > {2'b00, r_in_amount}) ?
                      (r_cooldown - {2'b00, r_in_amount}) : '0;
        w_over_sum  = {1'b0, r_over}  + {9'b0, r_in_amount};
        w_under_sum = {1'b0, r_under} + {9'b0, r_in_amount};

        unique case (r_class)
            CLASS_OVER: begin
                w_over_acc  = w_over_sum[ACC_W] ? '1 : w_over_sum[ACC_W-1:0];
                w_under_acc = '0;
            end
            CLASS_UNDER: begin
                w_over_acc  = '0;
                w_under_acc = w_under_sum[ACC_W] ? '1 : w_under_sum[ACC_W-1:0];
            end
            default: begin
                w_over_acc  = '0;
                w_under_acc = '0;
            end
        endcase

        w_step_up = (w_cd_dec == '0) && (w_over_acc >= {6'b0, r_cfg_downgrade})
                    && (r_level < LAST_LEVEL);
        w_step_dn = !w_step_up && (w_cd_dec == '0)
                    && (w_under_acc >= {6'b0, r_cfg_upgrade}) && (r_level != '0);

        n_class    = r_class;
        n_over     = r_over;
        n_under    = r_under;
        n_cooldown = r_cooldown;
        n_level    = r_level;
        n_changed  = 1'b0;

        if (r_in_kind == KIND_SAMPLE) begin
            n_class = w_sample_class;
        end else if (w_step_up || w_step_dn) begin
            n_changed  = 1'b1;
            n_level    = w_step_up ? (r_level + 3'd1) : (r_level - 3'd1);
            n_over     = '0;
            n_under    = '0;
            n_cooldown = r_cfg_cooldown;
        end else begin
            n_over     = w_over_acc;
            n_under    = w_under_acc;
            n_cooldown = w_cd_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_budget    <= BUDGET_RST;
            r_cfg_downgrade <= DOWNGRADE_RST;
            r_cfg_upgrade   <= UPGRADE_RST;
            r_cfg_cooldown  <= COOLDOWN_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_FRAME_BUDGET: r_cfg_budget    <= i_cfg_data[BUDGET_W-1:0];
                REG_DOWNGRADE:    r_cfg_downgrade <= i_cfg_data;
                REG_UPGRADE:      r_cfg_upgrade   <= i_cfg_data;
                REG_COOLDOWN:     r_cfg_cooldown  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_class     <= CLASS_NEUTRAL;
            r_over      <= '0;
            r_under     <= '0;
            r_cooldown  <= '0;
            r_level     <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (s_adv) begin
                r_out_valid <= 1'b1;
                r_class     <= n_class;
                r_over      <= n_over;
                r_under     <= n_under;
                r_cooldown  <= n_cooldown;
                r_level     <= n_level;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_kind   <= i_in.kind;
            r_in_amount <= i_in.amount_us;
        end
        if (s_adv) begin
            r_out_level   <= n_level;
            r_out_changed <= n_changed;
            r_out_class   <= n_class;
        end
    end

`ifndef SYNTH
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LAST_LEVEL)
        else $error("stage beyond last level");

    a_acc_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_over != '0) && (r_under != '0)))
        else $error("over and under accumulators both nonzero");

    a_step_cooldown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv && n_changed |=> (r_cooldown == $past(r_cfg_cooldown))
                               && (r_level != $past(r_level)))
        else $error("stage step did not restart cooldown");

    a_sample_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv && (r_in_kind == KIND_SAMPLE) |=> !r_out_changed)
        else $error("work sample stepped the stage");
`endif

endmodule

// ----- rtl/laqs_classify.sv -----
// Work sample classifier: over 1.05x budget, under 0.80x budget, else neutral.
`timescale 1ns / 1ps

module laqs_classify import laqs_pkg::*; (
    input  logic [AMOUNT_W-1:0] i_amount_us,
    input  logic [BUDGET_W-1:0] i_budget_us,
    output t_class              o_class
);

    logic [30:0] w_amt_x100;
    logic [30:0] w_bud_x105;
    logic [26:0] w_amt_x5;
    logic [26:0] w_bud_x4;

    // Exact integer compares, no rounding.
    assign w_amt_x100 = 31'(i_amount_us) * 31'd100;
    assign w_bud_x105 = 31'(i_budget_us) * 31'd105;
    assign w_amt_x5   = 27'(i_amount_us) * 27'd5;
    assign w_bud_x4   = {5'b0, i_budget_us, 2'b00};

    always_comb begin
        if (w_amt_x100 > w_bud_x105) begin
            o_class = CLASS_OVER;
        end else if (w_amt_x5 < w_bud_x4) begin
            o_class = CLASS_UNDER;
        end else begin
            o_class = CLASS_NEUTRAL;
        end
    end

endmodule

// ----- tb/tb_load_adaptive_quality_stepper.sv -----
// Self-checking testbench for the load-adaptive quality stepper.
`timescale 1ns / 1ps

module tb_load_adaptive_quality_stepper import laqs_pkg::*; ();

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               changed;
        t_class             cls;
    } t_level_report;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TIME_W-1:0]    cfg_data;

    laqs_in_if  in_if ();
    laqs_out_if out_if ();

    load_adaptive_quality_stepper i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Shadow copy of the block's registers and state.
    logic [BUDGET_W-1:0] budget_reg;
    logic [TIME_W-1:0]   down_thr;
    logic [TIME_W-1:0]   up_thr;
    logic [TIME_W-1:0]   cool_thr;
    t_class              cur_class;
    logic [ACC_W-1:0]    over_acc;
    logic [ACC_W-1:0]    under_acc;
    logic [TIME_W-1:0]   cool_left;
    logic [LEVEL_W-1:0]  level_now;

    t_level_report level_reports[$];
    int            errors;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            recv_hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("tb_load_adaptive_quality_stepper: FAIL");
        $finish;
    end

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                 input logic [AMOUNT_W-1:0] amount);
        logic [ACC_W:0] sum;
        sum = {1'b0, acc} + amount;
        return sum[ACC_W] ? '1 : sum[ACC_W-1:0];
    endfunction

    function automatic t_level_report stepper_update(input logic kind,
                                                     input logic [AMOUNT_W-1:0] amount);
        t_level_report rep;
        logic          stepped;
        stepped = 1'b0;
        if (kind == KIND_SAMPLE) begin
            if (64'(amount) * 100 > 64'(budget_reg) * 105)
                cur_class = CLASS_OVER;
            else if (64'(amount) * 5 < 64'(budget_reg) * 4)
                cur_class = CLASS_UNDER;
            else
                cur_class = CLASS_NEUTRAL;
        end else begin
            cool_left = (cool_left > amount) ? cool_left - amount : '0;
            case (cur_class)
                CLASS_OVER: begin
                    over_acc  = sat_add(over_acc, amount);
                    under_acc = '0;
                end
                CLASS_UNDER: begin
                    under_acc = sat_add(under_acc, amount);
                    over_acc  = '0;
                end
                default: begin
                    over_acc  = '0;
                    under_acc = '0;
                end
            endcase
            // step up has priority over step down
            if (cool_left == 0 && over_acc >= down_thr && level_now < LAST_LEVEL) begin
                level_now = level_now + 1'b1;
                stepped   = 1'b1;
            end else if (cool_left == 0 && under_acc >= up_thr && level_now != 0) begin
                level_now = level_now - 1'b1;
                stepped   = 1'b1;
            end
            if (stepped) begin
                over_acc  = '0;
                under_acc = '0;
                cool_left = cool_thr;
            end
        end
        rep.level   = level_now;
        rep.changed = stepped;
        rep.cls     = cur_class;
        return rep;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic kind, input logic [AMOUNT_W-1:0] amount);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.kind      <= kind;
        in_if.amount_us <= amount;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        level_reports.push_back(stepper_update(kind, amount));
        @(negedge i_clk);
    endtask

    task automatic drain;
        in_if.valid <= 1'b0;
        while (level_reports.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Writes all four registers back to back once the block is idle.
    task automatic configure(input logic [TIME_W-1:0] budget, input logic [TIME_W-1:0] down,
                             input logic [TIME_W-1:0] up, input logic [TIME_W-1:0] cool);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_BUDGET;
        cfg_data  <= budget;
        @(negedge i_clk);
        cfg_index <= REG_DOWNGRADE;
        cfg_data  <= down;
        @(negedge i_clk);
        cfg_index <= REG_UPGRADE;
        cfg_data  <= up;
        @(negedge i_clk);
        cfg_index <= REG_COOLDOWN;
        cfg_data  <= cool;
        @(negedge i_clk);
        cfg_we     <= 1'b0;
        budget_reg = budget[BUDGET_W-1:0];
        down_thr   = down;
        up_thr     = up;
        cool_thr   = cool;
        @(negedge i_clk);
    endtask

    // Result side: random stalls, plus a long hold-off when requested.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (recv_hold_left > 0) begin
                out_if.ready <= 1'b0;
                recv_hold_left--;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_level_report want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (level_reports.size() == 0) begin
                report_mismatch("result with nothing pending, level", out_if.level, -1);
            end else begin
                want = level_reports.pop_front();
                if (out_if.level !== want.level)
                    report_mismatch("level", out_if.level, want.level);
                if (out_if.level_changed !== want.changed)
                    report_mismatch("level_changed", out_if.level_changed, want.changed);
                if (out_if.load_class !== want.cls)
                    report_mismatch("load_class", out_if.load_class, want.cls);
            end
        end
    end

    // Class boundaries at the reset budget, then steps and cooldown with large ticks.
    task automatic test_budget_classes;
        send_item(KIND_SAMPLE, 24'd17501);
        send_item(KIND_SAMPLE, 24'd17500);
        send_item(KIND_SAMPLE, 24'd13333);
        send_item(KIND_SAMPLE, 24'd13334);
        send_item(KIND_SAMPLE, 24'd0);
        send_item(KIND_SAMPLE, 24'hFFFFFF);
        send_item(KIND_TICK, 24'd0);
        send_item(KIND_TICK, 24'hFFFFFF);
        send_item(KIND_TICK, 24'hFFFFFF);
        send_item(KIND_SAMPLE, 24'd0);
        send_item(KIND_TICK, 24'hFFFFFF);
        send_item(KIND_TICK, 24'd1);
    endtask

    // Zero thresholds and cooldown: every tick steps, even on a neutral class.
    task automatic test_zero_thresholds;
        configure(26'd1, '0, '0, '0);
        send_item(KIND_SAMPLE, 24'd1);
        repeat (7) send_item(KIND_TICK, 24'd0);
    endtask

    // Upper data bits set, so the 20-bit budget register ends up zero.
    task automatic test_zero_budget;
        configure(26'h3F00000, DOWNGRADE_RST, UPGRADE_RST, COOLDOWN_RST);
        send_item(KIND_SAMPLE, 24'd0);
        send_item(KIND_SAMPLE, 24'd1);
        send_item(KIND_SAMPLE, 24'hFFFFFF);
    endtask

    task automatic test_stage_bounds;
        configure(26'd100, 26'd10, 26'd10, '0);
        send_item(KIND_SAMPLE, 24'd200);
        repeat (6) send_item(KIND_TICK, 24'd10);
        send_item(KIND_SAMPLE, 24'd0);
        repeat (6) send_item(KIND_TICK, 24'd10);
    endtask

    // At stage 0 an under class never steps, so the accumulator runs into its ceiling.
    task automatic test_accumulator_saturation;
        configure(26'd1000, '1, '1, '0);
        send_item(KIND_SAMPLE, 24'd0);
        repeat (264) send_item(KIND_TICK, 24'hFFFFFF);
        send_item(KIND_SAMPLE, 24'hFFFFFF);
        repeat (4) send_item(KIND_TICK, 24'hFFFFFF);
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls.
    task automatic test_output_stall;
        configure(26'd500, 26'd300, 26'd300, 26'd200);
        recv_hold_left = 300;
        for (int k = 0; k < 40; k++) begin
            if (k % 5 == 0)
                send_item(KIND_SAMPLE, 24'($urandom_range(0, 1000)));
            else
                send_item(KIND_TICK, 24'($urandom_range(0, 200)));
        end
    endtask

    task automatic test_random_traffic(input int snd_idle, input int rcv_idle);
        int                  sent;
        int                  burst;
        longint              span;
        logic [AMOUNT_W-1:0] amt;
        send_idle_pct = snd_idle;
        recv_idle_pct = rcv_idle;
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: configure(26'($urandom_range(1, 2000)), 26'($urandom_range(0, 3000)),
                             26'($urandom_range(0, 3000)), 26'($urandom_range(0, 4000)));
                1: configure($urandom_range(1) ? {6'($urandom), 20'hFFFFF} : 26'd1,
                             $urandom_range(1) ? '1 : '0,
                             $urandom_range(1) ? 26'd60000000 : '0,
                             $urandom_range(1) ? '1 : '0);
                default: configure(26'(BUDGET_RST), DOWNGRADE_RST, UPGRADE_RST,
                                   COOLDOWN_RST);
            endcase
            span = (longint'(down_thr) + up_thr + cool_thr) / 8 + 16;
            if (span > 24'hFFFFFF) span = 24'hFFFFFF;
            sent = 0;
            while (sent < 37) begin
                if ($urandom_range(9) < 8) begin
                    // a sample followed by a few ticks
                    if ($urandom_range(99) < 75)
                        amt = 24'($urandom_range(0, 2 * budget_reg + 2));
                    else
                        amt = 24'($urandom);
                    send_item(KIND_SAMPLE, amt);
                    sent++;
                    burst = $urandom_range(1, 4);
                    repeat (burst) begin
                        case ($urandom_range(9))
                            0, 1: amt = 24'($urandom);
                            2:    amt = $urandom_range(1) ? 24'hFFFFFF : 24'd0;
                            default: amt = 24'($urandom_range(0, int'(span)));
                        endcase
                        send_item(KIND_TICK, amt);
                        sent++;
                    end
                end else begin
                    send_item(1'($urandom), 24'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_FRAME_BUDGET;
        cfg_data        = '0;
        in_if.valid     = 1'b0;
        in_if.kind      = KIND_SAMPLE;
        in_if.amount_us = '0;
        errors          = 0;
        recv_hold_left  = 0;
        send_idle_pct   = 21;
        recv_idle_pct   = 87;
        budget_reg      = BUDGET_RST;
        down_thr        = DOWNGRADE_RST;
        up_thr          = UPGRADE_RST;
        cool_thr        = COOLDOWN_RST;
        cur_class       = CLASS_NEUTRAL;
        over_acc        = '0;
        under_acc       = '0;
        cool_left       = '0;
        level_now       = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_budget_classes();
        test_zero_thresholds();
        test_zero_budget();
        test_stage_bounds();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_accumulator_saturation();
        test_output_stall();
        test_random_traffic(21, 87);
        test_random_traffic(87, 21);
        test_random_traffic(0, 0);

        drain();
        repeat (10) @(negedge i_clk);
        if (errors == 0) begin
            $display("tb_load_adaptive_quality_stepper: PASS");
        end else begin
            $display("tb_load_adaptive_quality_stepper: FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/laqs_pkg.sv
rtl/laqs_if.sv
rtl/laqs_classify.sv
rtl/load_adaptive_quality_stepper.sv
tb/tb_load_adaptive_quality_stepper.sv
